// ----- hdl/rmvs_pkg.sv -----
// rmvs_pkg: shared types and constants for the running mean / variance core
// no dependencies; imported by rmvs_div, running_mean_variance_stats_core and rmvs_checker
package rmvs_pkg;

    localparam int ACC_BITS = 64;
    localparam int VAR_BITS = 63;

    typedef struct packed {
        logic busy;
        logic done;
        logic rem_nz;
    } t_div_stat;

endpackage

// ----- hdl/rmvs_div.sv -----
// rmvs_div: radix-2 restoring divider, one quotient bit per cycle
// dividend is loaded left aligned; once i_iters quotient bits are shifted in, the register holds the quotient
// depends on rmvs_pkg
module rmvs_div
    import rmvs_pkg::*;
#(
    parameter int DVW = 65,
    parameter int CW = 32,
    localparam int ITW = $clog2(DVW + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [DVW-1:0] i_dividend,
    input  logic [ITW-1:0] i_iters,
    input  logic [CW-1:0]  i_divisor,
    output logic [DVW-1:0] o_quot,
    output t_div_stat      o_stat
);

    logic [DVW-1:0] r_num;
    logic [CW-1:0]  r_rem;
    logic [CW-1:0]  r_den;
    logic [ITW-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [CW:0]    w_shift;
    logic [CW:0]    w_diff;
    logic           w_ge;

    assign w_shift = {r_rem, r_num[DVW-1]};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign w_ge    = (w_shift >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_iters;
            end else if (r_busy) begin
                r_cnt <= r_cnt - ITW'(1);
                if (r_cnt == ITW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_num <= {r_num[DVW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[CW-1:0] : w_shift[CW-1:0];
        end
    end

    assign o_quot        = r_num;
    assign o_stat.busy   = r_busy;
    assign o_stat.done   = r_done;
    assign o_stat.rem_nz = |r_rem;

endmodule

// ----- hdl/running_mean_variance_stats_core.sv -----
// running_mean_variance_stats_core: online min, max, sum, count, mean and variance
// results are set by three serial divisions in rmvs_div and a serial square that overlaps
// the first; samples are taken one input beat at a time, and the next beat can be taken
// in the cycle after the result is registered
// the first sample skips the variance division
// synchronous active-low reset restarts the statistics; out_valid drops, in_ready rises
module running_mean_variance_stats_core
    import rmvs_pkg::*;
#(
    parameter int SAMPLE_BITS = 32,
    parameter int COUNT_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [COUNT_BITS-1:0]         o_running_count,
    output logic signed [ACC_BITS-1:0]    o_running_sum,
    output logic signed [SAMPLE_BITS-1:0] o_running_mean,
    output logic [VAR_BITS-1:0]           o_running_variance,
    output logic signed [SAMPLE_BITS-1:0] o_smallest_seen,
    output logic signed [SAMPLE_BITS-1:0] o_largest_seen
);

    localparam int GUARD = ((63 - SAMPLE_BITS) < 16) ? (63 - SAMPLE_BITS) : 16;
    localparam int MW    = SAMPLE_BITS + GUARD;
    localparam int MGW   = MW + 1;
    localparam int TW    = 2 * SAMPLE_BITS + 1;
    localparam int DVW   = (TW > ACC_BITS) ? TW : ACC_BITS;
    localparam int IW    = (TW > ACC_BITS) ? TW : ACC_BITS + 1;
    localparam int PW    = 2 * MGW + 1;
    localparam int ITW   = $clog2(DVW + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_MEAN = 3'd2;
    localparam logic [2:0] S_TDIV = 3'd3;
    localparam logic [2:0] S_ACC  = 3'd4;
    localparam logic [2:0] S_VDIV = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    localparam logic [ACC_BITS-1:0] SUM_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

    logic [2:0]                    r_state;
    logic signed [SAMPLE_BITS-1:0] r_min;
    logic signed [SAMPLE_BITS-1:0] r_max;
    logic [ACC_BITS-1:0]           r_sum;
    logic [COUNT_BITS-1:0]         r_count;
    logic [MW-1:0]                 r_mean;
    logic [ACC_BITS-1:0]           r_sq;
    logic [VAR_BITS-1:0]           r_var;
    logic [SAMPLE_BITS-1:0]        r_x;
    logic [MGW-1:0]                r_mag;
    logic                          r_neg;
    logic [PW-1:0]                 r_prod;
    logic [ACC_BITS-1:0]           r_inc;
    logic                          r_ovalid;
    logic [COUNT_BITS-1:0]         r_o_count;
    logic [ACC_BITS-1:0]           r_o_sum;
    logic [SAMPLE_BITS-1:0]        r_o_mean;
    logic [VAR_BITS-1:0]           r_o_var;
    logic [SAMPLE_BITS-1:0]        r_o_min;
    logic [SAMPLE_BITS-1:0]        r_o_max;

    logic                   w_in_beat;
    logic                   w_out_free;
    logic [ACC_BITS-1:0]    w_x64;
    logic [ACC_BITS-1:0]    w_sum;
    logic                   w_sum_ovf;
    logic [MW-1:0]          w_xg;
    logic [MGW-1:0]         w_d;
    logic [MGW-1:0]         w_mag;
    logic [MGW:0]           w_madd;
    logic [MGW-1:0]         w_mnew;
    logic [TW-1:0]          w_t;
    logic [TW-1:0]          w_c;
    logic [IW-1:0]          w_rx;
    logic [ACC_BITS:0]      w_sqsum;
    logic [ACC_BITS-1:0]    n_sq;
    logic [ACC_BITS-1:0]    w_v;
    logic                   w_multi;

    logic                   div_start;
    logic [DVW-1:0]         div_dividend;
    logic [ITW-1:0]         div_iters;
    logic [COUNT_BITS-1:0]  div_divisor;
    logic [DVW-1:0]         div_quot;
    t_div_stat              div_stat;

    assign w_in_beat  = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_ovalid || i_out_ready;
    assign w_multi    = (r_count > COUNT_BITS'(1));

    assign w_x64     = {{(ACC_BITS-SAMPLE_BITS){i_sample[SAMPLE_BITS-1]}}, i_sample};
    assign w_sum     = r_sum + w_x64;
    assign w_sum_ovf = (r_sum[ACC_BITS-1] == w_x64[ACC_BITS-1]) &&
                       (w_sum[ACC_BITS-1] != w_x64[ACC_BITS-1]);

    assign w_xg  = {r_x, {GUARD{1'b0}}};
    assign w_d   = {w_xg[MW-1], w_xg} - {r_mean[MW-1], r_mean};
    assign w_mag = w_d[MGW-1] ? (~w_d + MGW'(1)) : w_d;

    assign w_madd = r_prod[PW-1:MGW] + (r_prod[0] ? {1'b0, r_mag} : {(MGW+1){1'b0}});
    assign w_mnew = r_neg ? ({r_mean[MW-1], r_mean} - div_quot[MGW-1:0])
                          : ({r_mean[MW-1], r_mean} + div_quot[MGW-1:0]);

    assign w_t = r_prod[2*GUARD +: TW];
    assign w_c = div_quot[TW-1:0] + TW'(div_stat.rem_nz);
    assign w_rx = IW'(w_t - w_c);

    assign w_sqsum = {1'b0, r_sq} + {1'b0, r_inc};
    assign n_sq    = w_sqsum[ACC_BITS] ? {ACC_BITS{1'b1}} : w_sqsum[ACC_BITS-1:0];
    assign w_v     = div_quot[ACC_BITS-1:0];

    always_comb begin
        div_start    = 1'b0;
        div_dividend = DVW'(w_mag) << (DVW - MGW);
        div_iters    = ITW'(MGW);
        div_divisor  = r_count;
        unique case (r_state)
            S_PREP: begin
                div_start = 1'b1;
            end
            S_MEAN: begin
                div_start    = div_stat.done;
                div_dividend = DVW'(w_t) << (DVW - TW);
                div_iters    = ITW'(TW);
            end
            S_ACC: begin
                div_start    = w_multi;
                div_dividend = DVW'(n_sq) << (DVW - ACC_BITS);
                div_iters    = ITW'(ACC_BITS);
                div_divisor  = r_count - COUNT_BITS'(1);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    rmvs_div #(
        .DVW (DVW),
        .CW  (COUNT_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_iters    (div_iters),
        .i_divisor  (div_divisor),
        .o_quot     (div_quot),
        .o_stat     (div_stat)
    );

    // control and statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_min    <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            r_max    <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            r_sum    <= '0;
            r_count  <= '0;
            r_mean   <= '0;
            r_sq     <= '0;
            r_var    <= '0;
        end else begin
            if ((r_state == S_OUT) && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_beat) begin
                        if (i_sample < r_min) begin
                            r_min <= i_sample;
                        end
                        if (i_sample > r_max) begin
                            r_max <= i_sample;
                        end
                        if (w_sum_ovf) begin
                            r_sum <= w_x64[ACC_BITS-1] ? SUM_MIN : ~SUM_MIN;
                        end else begin
                            r_sum <= w_sum;
                        end
                        if (r_count != {COUNT_BITS{1'b1}}) begin
                            r_count <= r_count + COUNT_BITS'(1);
                        end
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_state <= S_MEAN;
                end
                S_MEAN: begin
                    if (div_stat.done) begin
                        r_mean  <= w_mnew[MW-1:0];
                        r_state <= S_TDIV;
                    end
                end
                S_TDIV: begin
                    if (div_stat.done) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_sq    <= n_sq;
                    r_state <= w_multi ? S_VDIV : S_OUT;
                end
                S_VDIV: begin
                    if (div_stat.done) begin
                        r_var   <= w_v[ACC_BITS-1] ? {VAR_BITS{1'b1}} : w_v[VAR_BITS-1:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_x <= i_sample;
        end
        if (r_state == S_PREP) begin
            r_mag  <= w_mag;
            r_neg  <= w_d[MGW-1];
            r_prod <= PW'(w_mag);
        end else if ((r_state == S_MEAN) && div_stat.busy) begin
            r_prod <= {w_madd, r_prod[MGW-1:0]} >> 1;
        end
        if ((r_state == S_TDIV) && div_stat.done) begin
            r_inc <= (|w_rx[IW-1:ACC_BITS]) ? {ACC_BITS{1'b1}} : w_rx[ACC_BITS-1:0];
        end
        if ((r_state == S_OUT) && w_out_free) begin
            r_o_count <= r_count;
            r_o_sum   <= r_sum;
            r_o_mean  <= r_mean[MW-1:GUARD];
            r_o_var   <= r_var;
            r_o_min   <= r_min;
            r_o_max   <= r_max;
        end
    end

    assign o_in_ready         = (r_state == S_IDLE);
    assign o_out_valid        = r_ovalid;
    assign o_running_count    = r_o_count;
    assign o_running_sum      = r_o_sum;
    assign o_running_mean     = r_o_mean;
    assign o_running_variance = r_o_var;
    assign o_smallest_seen    = r_o_min;
    assign o_largest_seen     = r_o_max;

endmodule

// ----- hdl/rmvs_checker.sv -----
// rmvs_checker: port-level assertions for running_mean_variance_stats_core
// depends on rmvs_pkg; attached to the core by the bind at the end of this file
module rmvs_checker
    import rmvs_pkg::*;
#(
    parameter int SAMPLE_BITS = 32,
    parameter int COUNT_BITS = 32
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [COUNT_BITS-1:0]         o_running_count,
    input logic signed [ACC_BITS-1:0]    o_running_sum,
    input logic signed [SAMPLE_BITS-1:0] o_running_mean,
    input logic [VAR_BITS-1:0]           o_running_variance,
    input logic signed [SAMPLE_BITS-1:0] o_smallest_seen,
    input logic signed [SAMPLE_BITS-1:0] o_largest_seen
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_running_sum))
        else $error("result beat changed while stalled");

    a_in_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while a sample is in progress");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_running_count != '0)
        else $error("result with zero count");

    a_mean_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_smallest_seen <= o_running_mean) &&
                        (o_running_mean <= o_largest_seen))
        else $error("mean outside min and max");

    a_first_variance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_running_count == COUNT_BITS'(1)) |-> o_running_variance == '0)
        else $error("variance not zero after first sample");

endmodule

bind running_mean_variance_stats_core rmvs_checker #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
) u_rmvs_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_ready         (o_in_ready),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_running_count    (o_running_count),
    .o_running_sum      (o_running_sum),
    .o_running_mean     (o_running_mean),
    .o_running_variance (o_running_variance),
    .o_smallest_seen    (o_smallest_seen),
    .o_largest_seen     (o_largest_seen)
);
